[rtl/core/nrm_pkg.sv]
// Shared constants and stage types for the vector normalizer.
package nrm_pkg;

  localparam int CW      = 24;              // component width
  localparam int SUM_W   = 2 * CW;          // sum of squares
  localparam int RAD_W   = SUM_W + 16;      // radicand, sum << 16
  localparam int ROOT_W  = RAD_W / 2;       // magnitude, Q.8
  localparam int REM_W   = ROOT_W + 2;      // root remainder
  localparam int QW      = 17;              // quotient bits, up to 65536
  localparam int UNIT_W  = 18;              // Q1.16 result
  localparam int LEN_W   = 32;              // length port width
  localparam int DVD_W   = CW + 24;         // component << 24
  localparam int LATENCY = 3 + ROOT_W + QW + 1;
  localparam logic [QW-1:0] UNIT_ONE = QW'(65536);

  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic [2:0]           neg;
    logic [2:0][CW-1:0]   mag;
    logic [RAD_W-1:0]     rad;
    logic [REM_W-1:0]     rem;
    logic [ROOT_W-1:0]    root;
  } nrm_sqrt_t;

  typedef struct packed {
    logic                   vld;
    logic                   zero;
    logic [2:0]             neg;
    logic [ROOT_W-1:0]      len;
    logic [2:0][ROOT_W-1:0] rem;
    logic [2:0][QW-1:0]     dvd;
    logic [2:0][QW-1:0]     quo;
  } nrm_div_t;

endpackage

[rtl/core/nrm_sqrt_cell.sv]
// One digit cell of the square root chain: one root bit per cycle.
module nrm_sqrt_cell import nrm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  nrm_sqrt_t din,
  output nrm_sqrt_t dout
);

  logic [REM_W+1:0] wide;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fit;

  always_comb begin
    wide  = {din.rem, din.rad[RAD_W-1 -: 2]};
    trial = {2'b00, din.root, 2'b01};
    diff  = wide - trial;
    fit   = (wide >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.zero <= din.zero;
    dout.neg  <= din.neg;
    dout.mag  <= din.mag;
    dout.rad  <= {din.rad[RAD_W-3:0], 2'b00};
    dout.rem  <= fit ? diff[REM_W-1:0] : wide[REM_W-1:0];
    dout.root <= {din.root[ROOT_W-2:0], fit};
  end

endmodule

[rtl/core/nrm_div_cell.sv]
// One cell of the divider chain: one quotient bit per lane per cycle.
module nrm_div_cell import nrm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  nrm_div_t din,
  output nrm_div_t dout
);

  logic [2:0][ROOT_W:0] wide;
  logic [2:0][ROOT_W:0] diff;
  logic [2:0]           fit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {din.rem[i], din.dvd[i][QW-1]};
      diff[i] = wide[i] - {1'b0, din.len};
      fit[i]  = (wide[i] >= {1'b0, din.len});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.zero <= din.zero;
    dout.neg  <= din.neg;
    dout.len  <= din.len;
    for (int i = 0; i < 3; i++) begin
      dout.rem[i] <= fit[i] ? diff[i][ROOT_W-1:0] : wide[i][ROOT_W-1:0];
      dout.dvd[i] <= {din.dvd[i][QW-2:0], 1'b0};
      dout.quo[i] <= {din.quo[i][QW-2:0], fit[i]};
    end
  end

endmodule

[rtl/core/vector3_normalize_core.sv]
// Vector normalizer top level: squares, root chain, divider chain, output.
//
// Takes one vector per clock and never stalls: busy is tied low. Each
// result passes through 3 front stages, 32 square root cells, 17 divider
// cells and 1 output register after its start transfer, and is marked
// by a one-cycle done strobe; the receiver must take it then.
// length_q8 = floor(sqrt(S << 16)) with S the sum of squares; each unit
// component is (c << 24) / length_q8 truncated toward zero and clamped
// to +/-65536. An all-zero vector gives zero outputs and zero_vector = 1.
module vector3_normalize_core import nrm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CW-1:0]     vec_x,
  input  logic signed [CW-1:0]     vec_y,
  input  logic signed [CW-1:0]     vec_z,
  output logic                     done,
  output logic signed [UNIT_W-1:0] unit_x,
  output logic signed [UNIT_W-1:0] unit_y,
  output logic signed [UNIT_W-1:0] unit_z,
  output logic [LEN_W-1:0]         length_q8,
  output logic                     zero_vector
);

  // stage 0: magnitudes and signs
  logic               s0_vld;
  logic [2:0]         s0_neg;
  logic [2:0][CW-1:0] s0_mag;
  // stage 1: squares, one multiplier per lane
  logic                  s1_vld;
  logic [2:0]            s1_neg;
  logic [2:0][CW-1:0]    s1_mag;
  logic [2:0][SUM_W-1:0] s1_sq;

  logic [SUM_W-1:0] sum;

  nrm_sqrt_t sq [0:ROOT_W];
  nrm_div_t  dv [0:QW];

  logic [2:0][DVD_W-1:0] dividend;
  logic [2:0][QW-1:0]    quo_clamped;
  logic [2:0][UNIT_W-1:0] unit_val;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
    end else begin
      s0_vld <= start;
      s1_vld <= s0_vld;
    end
    s0_neg <= {vec_z[CW-1], vec_y[CW-1], vec_x[CW-1]};
    s0_mag[0] <= vec_x[CW-1] ? CW'(-vec_x) : vec_x;
    s0_mag[1] <= vec_y[CW-1] ? CW'(-vec_y) : vec_y;
    s0_mag[2] <= vec_z[CW-1] ? CW'(-vec_z) : vec_z;
    s1_neg <= s0_neg;
    s1_mag <= s0_mag;
    for (int i = 0; i < 3; i++) begin
      s1_sq[i] <= SUM_W'(s0_mag[i]) * SUM_W'(s0_mag[i]);
    end
  end

  // three squares of |c| <= 2^(CW-1) stay below 2^SUM_W
  assign sum = s1_sq[0] + s1_sq[1] + s1_sq[2];

  // stage 2: seed of the root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].vld <= 1'b0;
    end else begin
      sq[0].vld <= s1_vld;
    end
    sq[0].zero <= (sum == '0);
    sq[0].neg  <= s1_neg;
    sq[0].mag  <= s1_mag;
    sq[0].rad  <= {sum, 16'h0000};
    sq[0].rem  <= '0;
    sq[0].root <= '0;
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    nrm_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (sq[g]),
      .dout (sq[g+1])
    );
  end

  // Divider seed: quotient fits QW bits since len >= 256*|c|, so the
  // dividend's bits above the low QW start as the partial remainder.
  always_comb begin
    dv[0].vld  = sq[ROOT_W].vld;
    dv[0].zero = sq[ROOT_W].zero;
    dv[0].neg  = sq[ROOT_W].neg;
    dv[0].len  = sq[ROOT_W].root;
    for (int i = 0; i < 3; i++) begin
      dividend[i]  = {sq[ROOT_W].mag[i], 24'h000000};
      dv[0].rem[i] = ROOT_W'(dividend[i] >> QW);
      dv[0].dvd[i] = dividend[i][QW-1:0];
      dv[0].quo[i] = '0;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    nrm_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (dv[g]),
      .dout (dv[g+1])
    );
  end

  // clamp, restore sign, force zeros for the zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_clamped[i] = (dv[QW].quo[i] > UNIT_ONE) ? UNIT_ONE : dv[QW].quo[i];
      if (dv[QW].zero) begin
        unit_val[i] = '0;
      end else if (dv[QW].neg[i]) begin
        unit_val[i] = UNIT_W'(-{1'b0, quo_clamped[i]});
      end else begin
        unit_val[i] = {1'b0, quo_clamped[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QW].vld;
    end
    unit_x      <= unit_val[0];
    unit_y      <= unit_val[1];
    unit_z      <= unit_val[2];
    length_q8   <= dv[QW].zero ? '0 : LEN_W'(dv[QW].len);
    zero_vector <= dv[QW].zero;
  end

endmodule

[rtl/core/vector3_normalize_checker.sv]
// Port-level checks for the vector normalizer, bound to the top level.
module vector3_normalize_checker import nrm_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic signed [UNIT_W-1:0] unit_x,
  input logic signed [UNIT_W-1:0] unit_y,
  input logic signed [UNIT_W-1:0] unit_z,
  input logic [LEN_W-1:0]         length_q8,
  input logic                     zero_vector
);

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after fixed latency");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && zero_vector) |-> (unit_x == 0 && unit_y == 0 && unit_z == 0
                               && length_q8 == 0))
    else $error("zero vector with nonzero outputs");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (unit_x <= 65536 && unit_x >= -65536 && unit_y <= 65536
              && unit_y >= -65536 && unit_z <= 65536 && unit_z >= -65536))
    else $error("unit component out of range");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !zero_vector) |-> (length_q8 >= 256))
    else $error("length too small for nonzero vector");

endmodule

bind vector3_normalize_core vector3_normalize_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .unit_x      (unit_x),
  .unit_y      (unit_y),
  .unit_z      (unit_z),
  .length_q8   (length_q8),
  .zero_vector (zero_vector)
);

[test/vector3_normalize_core_test.sv]
// Self-checking testbench for the vector3_normalize_core fixed-point normalizer.
module vector3_normalize_core_test;
  import nrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct {
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
    logic signed [UNIT_W-1:0] uz;
    logic [LEN_W-1:0]         len;
    logic                     zero;
  } unit_t;

  // Block has no stall and a fixed pipeline; allow generous slack at the end.
  localparam int DRAIN_CYCLES = LATENCY + 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] vec_x = '0;
  logic signed [CW-1:0] vec_y = '0;
  logic signed [CW-1:0] vec_z = '0;
  logic done;
  logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
  logic [LEN_W-1:0] length_q8;
  logic zero_vector;

  vec_t  pending_vecs[$];     // vectors waiting to be driven
  unit_t expected_units[$];   // predicted results, oldest first
  int    errors = 0;
  int    cycle_count = 0;
  bit    stim_done = 1'b0;
  bit    hold_for_drain = 1'b0;  // sender pauses until pipeline empties
  int    gap_left = 0;

  vector3_normalize_core dut (
    .clk, .rst, .start, .busy, .vec_x, .vec_y, .vec_z,
    .done, .unit_x, .unit_y, .unit_z, .length_q8, .zero_vector
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bit-serial floor square root of a 64-bit radicand.
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] rem, root, bitv;
    rem = n;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Q1.16 quotient (c << 24) / len, truncated toward zero, clamped to one.
  function automatic logic [UNIT_W-1:0] scaled_component(logic signed [CW-1:0] c,
                                                         logic [63:0] len);
    logic [63:0] mag, q;
    mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
    q = (mag << 24) / len;
    if (q > 64'd65536) q = 64'd65536;
    if (c < 0) q = -q;
    return q[UNIT_W-1:0];
  endfunction

  function automatic unit_t normalize_vec(vec_t v);
    unit_t r;
    logic [63:0] ax, ay, az, sum, len;
    ax = (v.x < 0) ? 64'(-64'(v.x)) : 64'(v.x);
    ay = (v.y < 0) ? 64'(-64'(v.y)) : 64'(v.y);
    az = (v.z < 0) ? 64'(-64'(v.z)) : 64'(v.z);
    sum = ax * ax + ay * ay + az * az;
    if (sum == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, len: '0, zero: 1'b1};
    end else begin
      len = floor_root(sum << 16);
      r.ux = scaled_component(v.x, len);
      r.uy = scaled_component(v.y, len);
      r.uz = scaled_component(v.z, len);
      r.len = len[LEN_W-1:0];
      r.zero = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Components biased toward interesting magnitudes: tiny, huge, extremes.
  function automatic logic signed [CW-1:0] rand_comp();
    int p;
    logic [CW-1:0] raw;
    p = $urandom_range(0, 9);
    raw = CW'($urandom);
    case (p)
      0: return '0;
      1: return CW'($signed($urandom_range(0, 6)) - 3);
      2: return {1'b1, {(CW-1){1'b0}}};
      3: return {1'b0, {(CW-1){1'b1}}};
      4: return CW'($signed($urandom_range(0, 2000)) - 1000);
      5: return raw >>> $urandom_range(0, CW - 1);
      default: return raw;
    endcase
  endfunction

  task automatic add_vec(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                         logic signed [CW-1:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    pending_vecs.push_back(v);
  endtask

  // Stimulus: directed corner vectors, then random ones in three batches with
  // a full drain between the batches.
  initial begin
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    add_vec(0, 0, 0);
    add_vec(1, 0, 0);
    add_vec(0, -1, 0);
    add_vec(0, 0, 1);
    add_vec(mx, 0, 0);
    add_vec(mn, 0, 0);
    add_vec(0, mn, 0);
    add_vec(0, 0, mx);
    add_vec(mx, mx, mx);
    add_vec(mn, mn, mn);
    add_vec(mx, mn, mx);
    add_vec(1, 1, 1);
    add_vec(-1, -1, -1);
    add_vec(3, 4, 0);
    add_vec(mx, 1, 1);     // dominant component: quotient lands on the 65536 limit
    add_vec(mn, -1, 1);
    add_vec(1000, 1, 0);
    add_vec(-7, 0, 0);
    add_vec(mx, mn, 0);
    add_vec(2, 0, 0);
    @(negedge clk);
    wait (!rst);
    for (int batch = 0; batch < 3; batch++) begin
      for (int i = 0; i < 250; i++) add_vec(rand_comp(), rand_comp(), rand_comp());
      wait (pending_vecs.size() == 0);
      // Pressure: hold off the sender until every result is back
      hold_for_drain = 1'b1;
      wait (expected_units.size() == 0);
      @(negedge clk);
      hold_for_drain = 1'b0;
    end
    stim_done = 1'b1;
  end

  // Driver: one transfer per accepted start, inputs change at falling edge.
  always @(negedge clk) begin
    if (cycle_count == 11) rst <= 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // transfer happened at the last rising edge
        expected_units.push_back(normalize_vec('{x: vec_x, y: vec_y, z: vec_z}));
        void'(pending_vecs.pop_front());
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_vecs.size() > 0 && !hold_for_drain) begin
        start <= 1'b1;
        vec_x <= pending_vecs[0].x;
        vec_y <= pending_vecs[0].y;
        vec_z <= pending_vecs[0].z;
      end else begin
        start <= 1'b0;
        vec_x <= CW'($urandom);   // noise while idle
        vec_y <= CW'($urandom);
        vec_z <= CW'($urandom);
      end
    end
  end

  // Monitor: results are sampled at the rising edge that ends the strobe.
  always @(posedge clk) begin
    unit_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_units.size() == 0) begin
        $error("result with no transfer outstanding");
        errors++;
      end else begin
        e = expected_units.pop_front();
        if (unit_x !== e.ux) begin
          $error("unit_x expected %0d got %0d", e.ux, unit_x);
          errors++;
        end
        if (unit_y !== e.uy) begin
          $error("unit_y expected %0d got %0d", e.uy, unit_y);
          errors++;
        end
        if (unit_z !== e.uz) begin
          $error("unit_z expected %0d got %0d", e.uz, unit_z);
          errors++;
        end
        if (length_q8 !== e.len) begin
          $error("length_q8 expected %0d got %0d", e.len, length_q8);
          errors++;
        end
        if (zero_vector !== e.zero) begin
          $error("zero_vector expected %0d got %0d", e.zero, zero_vector);
          errors++;
        end
      end
    end
  end

  // End of run: drain, then extra cycles to catch stray strobes.
  initial begin
    wait (stim_done && expected_units.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
